// ===== rtl/core/insertion_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// Insertion sorter assertion macros
// Shared property wrappers for the sorter checks, clocked on clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");

// Consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");

`endif

// ===== rtl/core/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter package
// Sizes, transfer payloads and the link and control structs of the cell row.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 16;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic                        batch_end;
  } load_item_t;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] sorted_key;
    logic                        last_result;
    logic                        overflowed;
  } emit_item_t;

  // State one cell shows to its neighbors.
  typedef struct packed {
    logic                        valid;
    logic                        gt;
    logic signed [KEY_WIDTH-1:0] key;
  } link_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                        insert;
    logic                        shift;
    logic signed [KEY_WIDTH-1:0] key;
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ===== rtl/core/isort_cell.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter cell
// One slot of the sorted row: compares the broadcast key against its own,
// takes the new key or its left neighbor's key on insert, and takes its
// right neighbor's key on a drain shift.
// ----------------------------------------------------------------------------
module isort_cell
  import isort_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctrl_t ctrl,
  input  link_t left,
  input  link_t right,
  output link_t link
);

  logic                        valid;
  logic signed [KEY_WIDTH-1:0] key;
  logic                        valid_next;
  logic signed [KEY_WIDTH-1:0] key_next;
  logic                        gt;

  // Strict compare keeps equal keys in arrival order.
  assign gt = valid && (key > ctrl.key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    priority if (ctrl.shift) begin
      valid_next = right.valid;
      key_next   = right.key;
    end else if (ctrl.insert) begin
      priority if (left.gt) begin
        valid_next = 1'b1;
        key_next   = left.key;
      end else if (gt || (!valid && left.valid)) begin
        valid_next = 1'b1;
        key_next   = ctrl.key;
      end else begin
        valid_next = valid;
        key_next   = key;
      end
    end else begin
      // Hold the slot.
      valid_next = valid;
      key_next   = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    key <= key_next;
  end

  assign link = '{valid: valid, gt: gt, key: key};

endmodule

// ===== rtl/core/insertion_sorter.sv =====
// Latency: a key is stored at the edge of its transfer; the first result of a
// batch is offered in the cycle after the batch_end transfer.
// Throughput: one key per cycle while loading (one compare in every cell);
// a batch then drains at one result per cycle while emit_stall is low,
// and the load side is stalled for the whole drain.
// Reset: all cells empty, drop flag clear, block ready to load.
// ----------------------------------------------------------------------------
// Insertion sorter
// Stable ascending sort of key batches in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`include "insertion_sorter_assert.svh"

module insertion_sorter
  import isort_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_stall,
  input  load_item_t load_item,
  output logic       emit_valid,
  input  logic       emit_stall,
  output emit_item_t emit_item
);

  state_t state;
  state_t state_next;
  logic   drop;
  logic   drop_next;
  ctrl_t  ctrl;
  link_t  links [DEPTH];
  link_t  head_link;
  link_t  tail_link;
  logic   load_xfer;
  logic   emit_xfer;
  logic   full;
  logic   last;

  assign head_link = '{valid: 1'b1, gt: 1'b0, key: '0};
  assign tail_link = '{valid: 1'b0, gt: 1'b0, key: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? tail_link : links[(i == DEPTH - 1) ? i : i + 1]),
      .link  (links[i])
    );
  end

  assign full       = links[DEPTH-1].valid;
  assign last       = !links[1].valid;
  assign load_stall = (state == ST_DRAIN);
  assign load_xfer  = load_valid && !load_stall;
  assign emit_valid = (state == ST_DRAIN);
  assign emit_xfer  = emit_valid && !emit_stall;

  assign ctrl = '{insert: load_xfer && !full, shift: emit_xfer, key: load_item.key};

  assign emit_item = '{sorted_key: links[0].key, last_result: last, overflowed: drop};

  always_comb begin
    state_next = state;
    drop_next  = drop;
    unique case (state)
      ST_LOAD: begin
        if (load_xfer && full) begin
          drop_next = 1'b1;
        end
        if (load_xfer && load_item.batch_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Drop the batch flag once the final result is taken.
        if (emit_xfer && last) begin
          state_next = ST_LOAD;
          drop_next  = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
        drop_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      drop  <= drop_next;
    end
  end

  `ISORT_ASSERT_NOW(a_drain_has_head, emit_valid, links[0].valid)
  `ISORT_ASSERT_NOW(a_row_sorted, links[0].valid && links[1].valid,
                    links[0].key <= links[1].key)
  `ISORT_ASSERT_NEXT(a_full_sets_drop, load_xfer && full, drop)
  `ISORT_ASSERT_NEXT(a_last_empties, emit_xfer && last,
                     (state == ST_LOAD) && !links[0].valid && !drop)

endmodule
